FILE: sv/debounced_buttons_long_press_top_macros.svh
// assertion macros shared by the debouncer rtl
// expects clk and arst_n in the scope of each use
`ifndef DEBOUNCED_BUTTONS_LONG_PRESS_TOP_MACROS_SVH
`define DEBOUNCED_BUTTONS_LONG_PRESS_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define DBLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true out of reset
`define DBLP_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define DBLP_ASSERT(lbl, prop, msg)
`define DBLP_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

FILE: sv/dblp_pkg.sv
// types, event codes and register defaults for the button debouncer
// no dependencies
package dblp_pkg;

	localparam int LEVEL_INPUTS = 3;
	localparam int TIME_W       = 32;
	localparam int MS_W         = 16;
	localparam int CFG_IDX_W    = 8;

	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [MS_W-1:0]      ms_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [2:0]           evt_t;

	localparam evt_t EVT_NONE   = 3'd0;
	localparam evt_t EVT_A      = 3'd1;
	localparam evt_t EVT_C_LONG = 3'd6;
	localparam int   LONG_OFS   = 3;

	localparam cfg_idx_t REG_DEBOUNCE   = 8'd0;
	localparam cfg_idx_t REG_LONG_PRESS = 8'd1;

	localparam ms_t DEBOUNCE_RST   = 16'd20;
	localparam ms_t LONG_PRESS_RST = 16'd800;

	typedef struct packed {
		logic  raw;
		logic  stable;
		logic  long_rep;
		time_t chg_time;
		time_t press_time;
	} btn_state_t;

	typedef struct packed {
		btn_state_t nxt;
		logic       fire;      // release that reports a press
		logic       is_long;
		logic       hold_due;  // hold threshold met on the updated state
	} btn_out_t;

	function automatic evt_t code_for(input int unsigned btn, input logic is_long);
		int unsigned v;
		v = btn + 1 + (is_long ? LONG_OFS : 0);
		if (btn >= LEVEL_INPUTS)
			return EVT_NONE;
		return evt_t'(v);
	endfunction

endpackage

FILE: sv/dblp_button.sv
// next-state logic of one debounced button: settle, press, release, hold check
// depends on dblp_pkg
module dblp_button (
	input  logic               level,
	input  dblp_pkg::time_t    now_ms,
	input  dblp_pkg::ms_t      debounce_ms,
	input  dblp_pkg::ms_t      long_press_ms,
	input  dblp_pkg::btn_state_t cur,
	output dblp_pkg::btn_out_t   res
);

	dblp_pkg::time_t chg_n;
	dblp_pkg::time_t since_chg;
	dblp_pkg::time_t held;
	dblp_pkg::time_t held_n;
	dblp_pkg::btn_state_t nxt;
	logic settle;
	logic fire;
	logic is_long;

	assign chg_n     = (level != cur.raw) ? now_ms : cur.chg_time;
	assign since_chg = now_ms - chg_n;
	assign held      = now_ms - cur.press_time;
	assign settle    = (cur.stable != level) &&
		!(since_chg < dblp_pkg::time_t'(debounce_ms));

	always_comb begin
		nxt          = cur;
		nxt.raw      = level;
		nxt.chg_time = chg_n;
		fire         = 1'b0;
		is_long      = 1'b0;
		if (settle) begin
			nxt.stable   = level;
			nxt.long_rep = 1'b0;
			if (level) begin
				nxt.press_time = now_ms;
			end else begin
				// release after a reported hold stays silent
				fire    = !cur.long_rep;
				is_long = !cur.long_rep && (held >= dblp_pkg::time_t'(long_press_ms));
			end
		end
	end

	assign held_n = now_ms - nxt.press_time;

	assign res.nxt      = nxt;
	assign res.fire     = fire;
	assign res.is_long  = is_long;
	assign res.hold_due = nxt.stable && !nxt.long_rep &&
		(held_n >= dblp_pkg::time_t'(long_press_ms));

endmodule

FILE: sv/debounced_buttons_long_press_top.sv
// button debouncer with short and long press events, one event code per tick
// depends on dblp_pkg, dblp_button and the assertion macro header
//
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  tick    | tick_valid tick_stall now_ms level_* | in
//  evt     | evt_valid evt_stall event_code      | out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | in
//
// a tick passes the input register, then all buttons are resolved in one pass
// into the event register and the button state.
// one tick per cycle sustained while events are not stalled; the input and event registers part the two sides.
// arst_n clears button state, the pipeline valids and loads the register defaults.
// a stalled event holds the event register and, once the input register is full,
// stalls the tick channel. cfg is always ready.
`include "debounced_buttons_long_press_top_macros.svh"

module debounced_buttons_long_press_top #(
	parameter int NUM_BUTTONS = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     tick_valid,
	output logic                     tick_stall,
	input  dblp_pkg::time_t          now_ms,
	input  logic                     level_a,
	input  logic                     level_b,
	input  logic                     level_c,
	output logic                     evt_valid,
	input  logic                     evt_stall,
	output dblp_pkg::evt_t           event_code,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  dblp_pkg::cfg_idx_t       cfg_index,
	input  dblp_pkg::ms_t            cfg_data
);

	dblp_pkg::ms_t        debounce_q;
	dblp_pkg::ms_t        long_press_q;
	logic                 valid_s1;
	dblp_pkg::time_t      now_s1;
	logic [2:0]           lvl_s1;
	logic                 evt_valid_q;
	dblp_pkg::evt_t       event_code_q;
	dblp_pkg::btn_state_t st_q   [NUM_BUTTONS];
	dblp_pkg::btn_state_t st_nxt [NUM_BUTTONS];
	dblp_pkg::btn_out_t   bo     [NUM_BUTTONS];
	dblp_pkg::evt_t       code_c;
	logic                 blocked;
	logic                 hold_found;
	logic                 advance;
	logic [NUM_BUTTONS-1:0] long_vec;
	logic [NUM_BUTTONS-1:0] stable_vec;

	assign cfg_ready  = 1'b1;
	assign advance    = !evt_valid_q || !evt_stall;
	assign tick_stall = valid_s1 && !advance;
	assign evt_valid  = evt_valid_q;
	assign event_code = event_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= dblp_pkg::DEBOUNCE_RST;
			long_press_q <= dblp_pkg::LONG_PRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dblp_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_data;
				dblp_pkg::REG_LONG_PRESS: long_press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			now_s1 <= now_ms;
			lvl_s1 <= {level_c, level_b, level_a};
		end
	end

	genvar g;
	generate
		for (g = 0; g < NUM_BUTTONS; g++) begin : gen_btn
			logic lvl;
			// buttons past the wired inputs read released
			if (g < dblp_pkg::LEVEL_INPUTS) begin : gen_wired
				assign lvl = lvl_s1[g];
			end else begin : gen_open
				assign lvl = 1'b0;
			end

			dblp_button u_btn (
				.level         (lvl),
				.now_ms        (now_s1),
				.debounce_ms   (debounce_q),
				.long_press_ms (long_press_q),
				.cur           (st_q[g]),
				.res           (bo[g])
			);

			assign long_vec[g]   = st_q[g].long_rep;
			assign stable_vec[g] = st_q[g].stable;
		end
	endgenerate

	// first reporting button ends the tick; later buttons keep their state
	always_comb begin
		blocked    = 1'b0;
		hold_found = 1'b0;
		code_c     = dblp_pkg::EVT_NONE;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			st_nxt[i] = st_q[i];
			if (!blocked) begin
				st_nxt[i] = bo[i].nxt;
				if (bo[i].fire &&
				    dblp_pkg::code_for(i, bo[i].is_long) != dblp_pkg::EVT_NONE) begin
					blocked = 1'b1;
					code_c  = dblp_pkg::code_for(i, bo[i].is_long);
				end
			end
		end
		if (!blocked) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (!hold_found && bo[i].hold_due) begin
					hold_found          = 1'b1;
					st_nxt[i].long_rep  = 1'b1;
					code_c              = dblp_pkg::code_for(i, 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				st_q[i] <= '0;
			end
		end else if (valid_s1 && advance) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				st_q[i] <= st_nxt[i];
			end
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (advance) begin
			evt_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			event_code_q <= code_c;
		end
	end

	// with a zero hold time a press reports its hold on the same tick
	`DBLP_ASSERT(a_code_range, evt_valid_q |-> (event_code_q <= dblp_pkg::EVT_C_LONG), "event code out of range")
	`DBLP_ASSERT_NEVER(a_long_needs_press, |(long_vec & ~stable_vec), "hold flag set on a released button")
	`DBLP_ASSERT(a_one_hold_per_tick, $onehot0(long_vec & ~$past(long_vec)), "more than one hold reported in a tick")
	`DBLP_ASSERT_NEVER(a_press_clears_hold, (long_press_q != '0) && |(stable_vec & ~$past(stable_vec) & long_vec), "new press kept a stale hold flag")

endmodule
